// ----- design/missing_data_marginal_accumulator_assert.svh -----
// Assertion macros shared by the checker of the marginal accumulator.
// Both sample on the rising edge of i_clk and stand down while i_rst_n is low.
`ifndef MISSING_DATA_MARGINAL_ACCUMULATOR_ASSERT_SVH
`define MISSING_DATA_MARGINAL_ACCUMULATOR_ASSERT_SVH

// A property that must hold at every clock edge.
`define MDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A condition that must never be seen at a clock edge.
`define MDM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- design/mdm_pkg.sv -----
package mdm_pkg;

    // Alphabet and tuple length limits of the meta-tuple encoding.
    localparam int MAX_ALPHABET  = 4;
    localparam int MAX_POSITIONS = 3;

    // Command kinds.
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ACC   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ALPHABET  = 1'b0;
    localparam logic CFG_POSITIONS = 1'b1;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef logic [1:0] t_digit;
    typedef t_digit [MAX_POSITIONS-1:0] t_digits;

    // One classified command as it travels through the queue.
    typedef struct packed {
        logic [1:0]  kind;
        logic        err;
        logic [2:0]  radix;
        logic [1:0]  npos;
        t_digits     digits;
        logic [31:0] freq;
        logic [6:0]  meta_index;
    } t_cmd;

endpackage

// ----- design/missing_data_marginal_accumulator.sv -----
// Channel    Direction  Transfer condition       Payload
// command    in         start high, busy low     i_kind, i_ordinary_index, i_freq, i_meta_index
// result     out        o_done high (one cycle)  o_value, o_error
// config     in         i_cfg_we high            i_cfg_idx, i_cfg_data
//
// A command is written into the queue, and the store sequencer takes it from the queue head when idle.
// Clear, rejected and unused commands finish straight from idle, a read after S_READ,
// and an accumulate after stepping S_ACC through the 2^T masks (T positions) and then S_DRAIN,
// with the store doing one read-modify-write per mask, overlapped across masks.
// Reset is synchronous: the store reads as all zero and the registers take 4 and 2.
// busy rises while the two-entry queue is full; results cannot be held off.
module missing_data_marginal_accumulator import mdm_pkg::*; #(
    parameter int STORE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_ordinary_index,
    input  logic [31:0] i_freq,
    input  logic [6:0]  i_meta_index,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [2:0]  i_cfg_data,
    output logic        o_done,
    output logic [31:0] o_value,
    output logic        o_error
);

    logic push;
    logic pop;
    logic empty;
    logic full;
    t_cmd cmd;
    t_cmd head;

    assign busy = full;

    // Front part: configuration and command classification.
    mdm_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_full           (full),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_ordinary_index (i_ordinary_index),
        .i_freq           (i_freq),
        .i_meta_index     (i_meta_index),
        .o_push           (push),
        .o_cmd            (cmd)
    );

    // Command queue.
    mdm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    // Back part: store and update sequencer.
    mdm_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_done  (o_done),
        .o_value (o_value),
        .o_error (o_error)
    );

endmodule

// ----- design/mdm_queue.sv -----
module mdm_queue import mdm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_head  = r_slot[r_rd_ptr];

    // Storage slots hold payload only.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/mdm_front.sv -----
module mdm_front import mdm_pkg::*; #(
    parameter int STORE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_full,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [2:0]  i_cfg_data,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_ordinary_index,
    input  logic [31:0] i_freq,
    input  logic [6:0]  i_meta_index,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam logic [7:0] DEPTH8 = 8'(STORE_DEPTH);

    logic [2:0] r_alphabet;
    logic [1:0] r_positions;
    logic [2:0] radix;
    logic [1:0] npos;
    logic [6:0] ordinary_count;
    logic [6:0] meta_count;
    logic       acc_err;
    logic       read_err;
    logic       err;

    // b to the power e for e of one to three, on narrow values.
    function automatic logic [6:0] small_pow(input logic [2:0] b, input logic [1:0] e);
        logic [6:0] r;
        r = 7'(b);
        if (e > 2'd1) begin
            r = 7'(r * 7'(b));
        end
        if (e > 2'd2) begin
            r = 7'(r * 7'(b));
        end
        return r;
    endfunction

    // Split an ordinary index into digits of radix two, three or four,
    // least significant first. Division by three uses a reciprocal multiply.
    function automatic t_digits split_digits(input logic [5:0] x, input logic [2:0] a);
        t_digits     d;
        logic [5:0]  rem;
        logic [5:0]  q;
        logic [12:0] prod;
        rem = x;
        d   = '0;
        for (int j = 0; j < MAX_POSITIONS; j++) begin
            case (a)
                3'd2: begin
                    d[j] = {1'b0, rem[0]};
                    rem  = rem >> 1;
                end
                3'd3: begin
                    prod = 13'(rem) * 13'd43;
                    q    = prod[12:7];
                    d[j] = 2'(rem - 6'(q * 6'd3));
                    rem  = q;
                end
                default: begin
                    d[j] = rem[1:0];
                    rem  = rem >> 2;
                end
            endcase
        end
        return d;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet  <= 3'd4;
            r_positions <= 2'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHABET:  r_alphabet  <= i_cfg_data;
                CFG_POSITIONS: r_positions <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Effective radix and tuple length, saturated into their legal ranges.
    always_comb begin
        if (r_alphabet < 3'd2) begin
            radix = 3'd2;
        end else if (r_alphabet > 3'(MAX_ALPHABET)) begin
            radix = 3'(MAX_ALPHABET);
        end else begin
            radix = r_alphabet;
        end
        if (r_positions == 2'd0) begin
            npos = 2'd1;
        end else if (32'(r_positions) > MAX_POSITIONS) begin
            npos = 2'(MAX_POSITIONS);
        end else begin
            npos = r_positions;
        end
    end

    // Range checks against the ordinary and meta index spaces.
    assign ordinary_count = small_pow(radix, npos);
    assign meta_count     = small_pow(3'(radix + 3'd1), npos);
    assign acc_err  = ({1'b0, i_ordinary_index} >= ordinary_count)
                   || ({1'b0, meta_count} > DEPTH8);
    assign read_err = (i_meta_index >= meta_count) || ({1'b0, i_meta_index} >= DEPTH8);

    always_comb begin
        case (i_kind)
            KIND_ACC:  err = acc_err;
            KIND_READ: err = read_err;
            default:   err = 1'b0;
        endcase
    end

    // Classified command towards the queue.
    assign o_push            = i_start && !i_full;
    assign o_cmd.kind        = i_kind;
    assign o_cmd.err         = err;
    assign o_cmd.radix       = radix;
    assign o_cmd.npos        = npos;
    assign o_cmd.digits      = split_digits(i_ordinary_index, radix);
    assign o_cmd.freq        = i_freq;
    assign o_cmd.meta_index  = i_meta_index;

endmodule

// ----- design/mdm_back.sv -----
module mdm_back import mdm_pkg::*; #(
    parameter int STORE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_head,
    output logic        o_pop,
    output logic        o_done,
    output logic [31:0] o_value,
    output logic        o_error
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_ACC   = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [31:0]              mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]   r_valid;
    logic [1:0]               r_state;
    t_cmd                     r_cmd;
    logic [MAX_POSITIONS-1:0] r_mask;
    logic [MAX_POSITIONS-1:0] last_mask;
    logic [31:0]              r_rd_data;
    logic                     r_rd_valid;
    logic [AW-1:0]            r_wr_addr;
    logic                     r_wr_pend;
    logic                     r_done;
    logic [31:0]              r_value;
    logic                     r_error;
    logic [6:0]               acc_idx;
    logic [6:0]               weight;
    logic [2:0]               sel;
    logic [AW-1:0]            rd_addr;
    logic [32:0]              sum;
    logic [31:0]              wdata;
    logic                     clear_now;

    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign clear_now = o_pop && (i_head.kind == KIND_CLEAR);

    // Last missing-data mask: one bit set for each position in use.
    always_comb begin
        for (int j = 0; j < MAX_POSITIONS; j++) begin
            last_mask[j] = (j < 32'(r_cmd.npos));
        end
    end

    // Meta index of the current mask: masked positions carry the radix digit.
    always_comb begin
        acc_idx = '0;
        weight  = 7'd1;
        sel     = '0;
        for (int j = 0; j < MAX_POSITIONS; j++) begin
            sel = r_mask[j] ? r_cmd.radix : {1'b0, r_cmd.digits[j]};
            if (j < 32'(r_cmd.npos)) begin
                acc_idx = 7'(acc_idx + 7'(weight * 7'(sel)));
            end
            weight = 7'(weight * 7'(r_cmd.radix + 3'd1));
        end
    end

    // A read command addresses the store straight from the queue head.
    assign rd_addr = (r_state == S_IDLE) ? AW'(i_head.meta_index) : AW'(acc_idx);

    // Saturating add of the frequency to the registered read of the entry.
    assign sum   = {1'b0, (r_rd_valid ? r_rd_data : 32'd0)} + {1'b0, r_cmd.freq};
    assign wdata = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    // Store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            mem[r_wr_addr] <= wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Entry valid bits; an invalid entry reads as zero, so a clear only resets these bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (clear_now) begin
                r_valid <= '0;
            end else if (r_wr_pend) begin
                r_valid[r_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    // Sequencer: reads of mask m overlap the write-back of mask m-1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmd     <= '0;
            r_mask    <= '0;
            r_wr_addr <= '0;
            r_wr_pend <= 1'b0;
            r_done    <= 1'b0;
            r_value   <= '0;
            r_error   <= 1'b0;
        end else begin
            r_done    <= 1'b0;
            r_value   <= '0;
            r_error   <= 1'b0;
            r_wr_pend <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_head;
                        if (i_head.kind == KIND_READ && !i_head.err) begin
                            r_state <= S_READ;
                        end else if (i_head.kind == KIND_ACC && !i_head.err) begin
                            r_mask  <= '0;
                            r_state <= S_ACC;
                        end else begin
                            r_done  <= 1'b1;
                            r_error <= i_head.err;
                        end
                    end
                end
                S_READ: begin
                    r_done  <= 1'b1;
                    r_value <= r_rd_valid ? r_rd_data : 32'd0;
                    r_state <= S_IDLE;
                end
                S_ACC: begin
                    r_wr_pend <= 1'b1;
                    r_wr_addr <= rd_addr;
                    r_mask    <= r_mask + 1'b1;
                    if (r_mask == last_mask) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;
    assign o_error = r_error;

endmodule

// ----- design/mdm_checker.sv -----
`include "missing_data_marginal_accumulator_assert.svh"

module mdm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [31:0] o_value,
    input logic        o_error
);

    // The queue only fills through an accepted command.
    `MDM_ASSERT(a_busy_rise, $rose(busy) |-> $past(start && !busy), "busy rose without a transfer")

    // A rejected command never returns data.
    `MDM_ASSERT_NEVER(a_err_value, o_done && o_error && (o_value != 32'd0), "error with data")

    // Result ports are quiet between strobes.
    `MDM_ASSERT(a_quiet, !o_done |-> (o_value == 32'd0) && !o_error, "result ports not quiet")

endmodule

bind missing_data_marginal_accumulator mdm_checker u_mdm_checker (.*);

// ----- test/tb_missing_data_marginal_accumulator.sv -----
module tb_missing_data_marginal_accumulator;
    import mdm_pkg::*;

    localparam int          STORE_ENTRIES = 128;
    localparam int unsigned CYCLE_LIMIT   = 250000;
    localparam int unsigned PHASE_ITEMS   = 105;
    localparam int unsigned PHASE_COUNT   = 13;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;

    // One result as the block reports it.
    typedef struct packed {
        logic [31:0] value;
        logic        error;
    } t_marginal_result;

    // One row of the directed table; the typed-in result is used when pinned is set.
    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  ordinary_index;
        logic [31:0] freq;
        logic [6:0]  meta_index;
        logic        pinned;
        logic [31:0] value;
        logic        error;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [5:0]  i_ordinary_index;
    logic [31:0] i_freq;
    logic [6:0]  i_meta_index;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [2:0]  i_cfg_data;
    logic        o_done;
    logic [31:0] o_value;
    logic        o_error;

    // Shadow copy of the store and the shape registers.
    logic [31:0] model_store [STORE_ENTRIES];
    logic [2:0]  alphabet_reg;
    logic [1:0]  positions_reg;

    t_marginal_result pending_marginals [$];
    t_directed_row    directed_rows [$];
    int unsigned      mismatch_count;
    int unsigned      cycle_count;
    logic             idling_on;

    // Shape settings walked by the random phases, out-of-range values among them.
    int unsigned phase_alpha [PHASE_COUNT] = '{2, 4, 3, 0, 7, 5, 1, 2, 3, 4, 6, 3, 4};
    int unsigned phase_npos  [PHASE_COUNT] = '{1, 3, 2, 0, 3, 1, 2, 3, 3, 1, 2, 1, 2};

    missing_data_marginal_accumulator #(
        .STORE_DEPTH(STORE_ENTRIES)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_ordinary_index (i_ordinary_index),
        .i_freq           (i_freq),
        .i_meta_index     (i_meta_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_value          (o_value),
        .o_error          (o_error)
    );

    always #6 i_clk = ~i_clk;

    // Effective radix and tuple length, with the sizes of the ordinary and meta spaces.
    function automatic void shape_of_space(output int unsigned radix,
                                           output int unsigned npos,
                                           output int unsigned tuples,
                                           output int unsigned metas);
        int unsigned j;
        radix = alphabet_reg;
        if (radix < 2) radix = 2;
        if (radix > MAX_ALPHABET) radix = MAX_ALPHABET;
        npos = positions_reg;
        if (npos < 1) npos = 1;
        if (npos > MAX_POSITIONS) npos = MAX_POSITIONS;
        tuples = 1;
        metas  = 1;
        for (j = 0; j < npos; j++) begin
            tuples = tuples * radix;
            metas  = metas * (radix + 1);
        end
    endfunction

    // Applies one command to the shadow store and returns the result it should give.
    function automatic t_marginal_result apply_marginal_command(input logic [1:0]  kind,
                                                                input logic [5:0]  oidx,
                                                                input logic [31:0] freq,
                                                                input logic [6:0]  midx);
        t_marginal_result res;
        int unsigned radix, npos, tuples, metas, rem, idx, weight, j, mask;
        int unsigned digit [MAX_POSITIONS];
        logic [32:0] sum;
        res.value = '0;
        res.error = 1'b0;
        shape_of_space(radix, npos, tuples, metas);
        case (kind)
            KIND_CLEAR: begin
                for (j = 0; j < STORE_ENTRIES; j++) model_store[j] = '0;
            end
            KIND_ACC: begin
                if (oidx >= tuples || metas > STORE_ENTRIES) begin
                    res.error = 1'b1;
                end else begin
                    rem = oidx;
                    for (j = 0; j < npos; j++) begin
                        digit[j] = rem % radix;
                        rem      = rem / radix;
                    end
                    // Every missing-data mask gets the frequency, saturating.
                    for (mask = 0; mask < (1 << npos); mask++) begin
                        idx    = 0;
                        weight = 1;
                        for (j = 0; j < npos; j++) begin
                            idx    = idx + (((mask >> j) & 1) != 0 ? radix : digit[j]) * weight;
                            weight = weight * (radix + 1);
                        end
                        if (idx < STORE_ENTRIES) begin
                            sum = {1'b0, model_store[idx]} + {1'b0, freq};
                            model_store[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        end
                    end
                end
            end
            KIND_READ: begin
                if (midx >= metas || midx >= STORE_ENTRIES) res.error = 1'b1;
                else res.value = model_store[midx];
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Presents one command and holds it over a clock edge, then for as long as busy reads high after an edge.
    task automatic send_command(input logic [1:0]  kind,
                                input logic [5:0]  oidx,
                                input logic [31:0] freq,
                                input logic [6:0]  midx);
        if (idling_on && $urandom_range(99, 0) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_kind           <= kind;
        i_ordinary_index <= oidx;
        i_freq           <= freq;
        i_meta_index     <= midx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_marginals.size() != 0) @(posedge i_clk);
    endtask

    // Writes both shape registers back to back; only called while the block is idle.
    task automatic load_shape(input logic [2:0] alpha, input logic [1:0] npos);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ALPHABET;
        i_cfg_data <= alpha;
        @(posedge i_clk);
        alphabet_reg = alpha;
        i_cfg_idx  <= CFG_POSITIONS;
        i_cfg_data <= {1'b0, npos};
        @(posedge i_clk);
        positions_reg = npos;
        i_cfg_we <= 1'b0;
    endtask

    // Random commands: mostly in-range accumulates and reads, with some noise.
    task automatic run_random_phase(input int unsigned count);
        int unsigned radix, npos, tuples, metas, pick, n;
        logic [1:0]  kind;
        logic [5:0]  oidx;
        logic [31:0] freq;
        logic [6:0]  midx;
        shape_of_space(radix, npos, tuples, metas);
        for (n = 0; n < count; n++) begin
            kind = KIND_ACC;
            oidx = $urandom_range(63, 0);
            midx = $urandom_range(127, 0);
            pick = $urandom_range(99, 0);
            if (pick < 45) begin
                oidx = $urandom_range(tuples - 1, 0);
            end else if (pick < 50) begin
                kind = KIND_ACC;
            end else if (pick < 85) begin
                kind = KIND_READ;
                midx = $urandom_range(metas - 1, 0);
            end else if (pick < 92) begin
                kind = KIND_READ;
            end else if (pick < 96) begin
                kind = KIND_CLEAR;
            end else begin
                kind = KIND_UNUSED;
            end
            case ($urandom_range(9, 0))
                0:       freq = 32'h8000_0000;
                1:       freq = $urandom;
                2:       freq = $urandom_range(255, 0);
                default: freq = $urandom_range(32'h8000_0000, 0);
            endcase
            // Halfway through, let the pipeline drain completely once.
            if (n == count / 2) wait_for_results();
            send_command(kind, oidx, freq, midx);
            pending_marginals.push_back(apply_marginal_command(kind, oidx, freq, midx));
        end
    endtask

    // Result checker: each transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_marginal_result wanted;
        if (i_rst_n && o_done) begin
            if (pending_marginals.size() == 0) begin
                $error("unexpected result: value=%h error=%b", o_value, o_error);
                mismatch_count++;
            end else begin
                wanted = pending_marginals.pop_front();
                if (o_value !== wanted.value) begin
                    $error("value: expected %h, got %h", wanted.value, o_value);
                    mismatch_count++;
                end
                if (o_error !== wanted.error) begin
                    $error("error: expected %b, got %b", wanted.error, o_error);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** missing_data_marginal_accumulator: FAILED **");
            $finish;
        end
    end

    initial begin
        t_marginal_result predicted;
        int unsigned      p;
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_kind           <= KIND_CLEAR;
        i_ordinary_index <= '0;
        i_freq           <= '0;
        i_meta_index     <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_ALPHABET;
        i_cfg_data       <= '0;
        mismatch_count   = 0;
        cycle_count      = 0;
        idling_on        = 1'b1;
        alphabet_reg     = 3'd4;
        positions_reg    = 2'd2;
        for (p = 0; p < STORE_ENTRIES; p++) model_store[p] = '0;

        // Directed table, run under the reset shape of four characters and two positions.
        directed_rows.push_back('{KIND_READ,   6'd0,  32'h0,         7'd0,   1'b1, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_READ,   6'd0,  32'h0,         7'd24,  1'b1, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_READ,   6'd0,  32'h0,         7'd25,  1'b1, 32'h0, 1'b1});
        directed_rows.push_back('{KIND_READ,   6'd63, 32'hFFFF_FFFF, 7'd127, 1'b1, 32'h0, 1'b1});
        directed_rows.push_back('{KIND_ACC,    6'd16, 32'h8000_0000, 7'd0,   1'b1, 32'h0, 1'b1});
        directed_rows.push_back('{KIND_ACC,    6'd63, 32'h8000_0000, 7'd127, 1'b1, 32'h0, 1'b1});
        directed_rows.push_back('{KIND_ACC,    6'd0,  32'h8000_0000, 7'd0,   1'b1, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_ACC,    6'd15, 32'h8000_0000, 7'd0,   1'b1, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_READ,   6'd0,  32'h0,         7'd24,  1'b0, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_ACC,    6'd15, 32'hFFFF_FFFF, 7'd0,   1'b1, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_READ,   6'd0,  32'h0,         7'd24,  1'b0, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_READ,   6'd0,  32'h0,         7'd0,   1'b0, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_READ,   6'd0,  32'h0,         7'd18,  1'b0, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_UNUSED, 6'd63, 32'hFFFF_FFFF, 7'd127, 1'b1, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_READ,   6'd0,  32'h0,         7'd4,   1'b0, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_CLEAR,  6'd63, 32'hFFFF_FFFF, 7'd127, 1'b1, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_READ,   6'd0,  32'h0,         7'd24,  1'b1, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_ACC,    6'd5,  32'h1,         7'd0,   1'b1, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_READ,   6'd0,  32'h0,         7'd6,   1'b0, 32'h0, 1'b0});
        directed_rows.push_back('{KIND_READ,   6'd0,  32'h0,         7'd9,   1'b0, 32'h0, 1'b0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_command(directed_rows[r].kind, directed_rows[r].ordinary_index,
                         directed_rows[r].freq, directed_rows[r].meta_index);
            predicted = apply_marginal_command(directed_rows[r].kind,
                                               directed_rows[r].ordinary_index,
                                               directed_rows[r].freq,
                                               directed_rows[r].meta_index);
            if (directed_rows[r].pinned) begin
                predicted.value = directed_rows[r].value;
                predicted.error = directed_rows[r].error;
            end
            pending_marginals.push_back(predicted);
        end

        // Random phases, each under a new shape; the second runs with no idling at all.
        for (p = 0; p < PHASE_COUNT; p++) begin
            wait_for_results();
            repeat (4) @(posedge i_clk);
            load_shape(phase_alpha[p][2:0], phase_npos[p][1:0]);
            idling_on = (p != 1);
            run_random_phase(PHASE_ITEMS);
        end

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** missing_data_marginal_accumulator: PASSED **");
        end else begin
            $display("** missing_data_marginal_accumulator: FAILED **");
        end
        $finish;
    end

endmodule
